>>> rtl/core/wmpb_pkg.sv
// shared types, register indexes and helpers for the window masked pixel blender
// no dependencies; imported by every module of the block
package wmpb_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COEF_W  = 5;
  localparam int unsigned PROD_W  = CHAN_W + COEF_W;
  localparam int unsigned LAYER_W = 3;
  localparam int unsigned MASK_W  = 6;
  localparam int unsigned EN_W    = 3 * MASK_W;
  localparam int unsigned RECT_W  = 32;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned NCHAN   = 3;

  // configuration register indexes
  typedef enum logic [ADDR_W-1:0] {
    REG_WIN0_RECT  = 3'd0,
    REG_WIN1_RECT  = 3'd1,
    REG_WIN_EN     = 3'd2,
    REG_BLEND_MODE = 3'd3,
    REG_COEFF_A    = 3'd4,
    REG_COEFF_B    = 3'd5,
    REG_BRIGHTNESS = 3'd6
  } reg_idx_t;

  // blend mode register codes
  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_ALPHA  = 2'd1,
    MODE_BRIGHT = 2'd2,
    MODE_DARK   = 2'd3
  } mode_t;

  // per-pixel operation decided in the window stage
  typedef enum logic [2:0] {
    OP_KEEP   = 3'd0,
    OP_PASS   = 3'd1,
    OP_ALPHA  = 3'd2,
    OP_BRIGHT = 3'd3,
    OP_DARK   = 3'd4
  } op_t;

  localparam logic [LAYER_W-1:0] LAYER_OBJ = 3'd4;
  localparam int unsigned FX_BIT = 5;

  // load strobes of the three pipeline stages
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pipe_ctl_t;

  // saturate a weight to sixteen
  function automatic logic [COEF_W-1:0] sat16(input logic [COEF_W-1:0] v);
    sat16 = (v > 5'd16) ? 5'd16 : v;
  endfunction

  // start <= end covers [start, end); start > end wraps around
  function automatic logic span_holds(input logic [7:0] lo, input logic [7:0] hi,
                                      input logic [7:0] v);
    if (lo <= hi) begin
      span_holds = (v >= lo) && (v < hi);
    end else begin
      span_holds = (v >= lo) || (v < hi);
    end
  endfunction

  function automatic logic inside_rect(input logic [RECT_W-1:0] rect,
                                       input logic [7:0] x, input logic [7:0] y);
    inside_rect = span_holds(rect[7:0], rect[15:8], x) &&
                  span_holds(rect[23:16], rect[31:24], y);
  endfunction

endpackage

>>> rtl/core/window_masked_pixel_blender.sv
// top level of the window masked pixel blender: config registers, stream
// handshake and the three-stage pipeline; depends on wmpb_pkg, wmpb_win, wmpb_mix
//
// Usage:
//   Input stream in_*: one pixel per transfer. in_tdata carries the position
//   and both colors, in_tuser the layer number (0-3 backgrounds, 4 objects).
//   Output stream out_*: one result per input transfer, in order. out_tuser
//   is the write enable; out_tdata holds the colors (the frame color when
//   the write enable is low).
//   Config port: cfg_we writes register cfg_addr with cfg_wdata;
//   write only while no pixel is in flight.
// Pipeline and rate:
//   one pixel per cycle sustained while out_tready is high. Stage 1 is the window
//   compare and mask select, stage 2 the 8x5 channel multipliers, stage 3 the
//   add, scale and clamp.
// Reset:
//   rst_n low clears all config registers to zero and empties the pipeline.
// Stall:
//   each stage holds while the stage after it is full and stalled; bubbles
//   are squeezed out, so in_tready drops only when all three stages are full
//   and out_tready is low.
module window_masked_pixel_blender (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic [wmpb_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [wmpb_pkg::RECT_W-1:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // pixel_x, pixel_y, src_red, src_green, src_blue, dst_red, dst_green, dst_blue
  input  logic [63:0] in_tdata,
  // layer
  input  logic [wmpb_pkg::LAYER_W-1:0] in_tuser,
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_red, out_green, out_blue
  output logic [23:0] out_tdata,
  // write_enable
  output logic        out_tuser
);
  import wmpb_pkg::*;

  logic [RECT_W-1:0] win0_r, win1_r;
  logic [EN_W-1:0]   win_en_r;
  logic [1:0]        mode_r;
  logic [COEF_W-1:0] ca_r, cb_r, br_r;
  logic [COEF_W-1:0] ca_sat, cb_sat, ev_sat;

  logic [2:0]        vld_r;
  logic [2:0]        vld_nxt;
  logic              rdy3, rdy2, rdy1;
  pipe_ctl_t         ctl;

  op_t               op1_r;
  logic [CHAN_W-1:0] src1_r [NCHAN];
  logic [CHAN_W-1:0] dst1_r [NCHAN];
  logic              we2_r, we3_r;
  logic [CHAN_W-1:0] res [NCHAN];

  // config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r   <= '0;
      win1_r   <= '0;
      win_en_r <= '0;
      mode_r   <= '0;
      ca_r     <= '0;
      cb_r     <= '0;
      br_r     <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_WIN0_RECT:  win0_r   <= cfg_wdata;
        REG_WIN1_RECT:  win1_r   <= cfg_wdata;
        REG_WIN_EN:     win_en_r <= cfg_wdata[EN_W-1:0];
        REG_BLEND_MODE: mode_r   <= cfg_wdata[1:0];
        REG_COEFF_A:    ca_r     <= cfg_wdata[COEF_W-1:0];
        REG_COEFF_B:    cb_r     <= cfg_wdata[COEF_W-1:0];
        REG_BRIGHTNESS: br_r     <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign ca_sat = sat16(ca_r);
  assign cb_sat = sat16(cb_r);
  assign ev_sat = sat16(br_r);

  // stage readiness: a stage loads when it is empty or its item moves on
  assign rdy3      = out_tready || !vld_r[2];
  assign rdy2      = rdy3 || !vld_r[1];
  assign rdy1      = rdy2 || !vld_r[0];
  assign in_tready = rdy1;

  assign ctl.ld1 = rdy1;
  assign ctl.ld2 = rdy2;
  assign ctl.ld3 = rdy3;

  always_comb begin
    vld_nxt = vld_r;
    if (rdy1) vld_nxt[0] = in_tvalid;
    if (rdy2) vld_nxt[1] = vld_r[0];
    if (rdy3) vld_nxt[2] = vld_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1 color capture
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      src1_r[0] <= in_tdata[23:16];
      src1_r[1] <= in_tdata[31:24];
      src1_r[2] <= in_tdata[39:32];
      dst1_r[0] <= in_tdata[47:40];
      dst1_r[1] <= in_tdata[55:48];
      dst1_r[2] <= in_tdata[63:56];
    end
  end

  wmpb_win u_win (
    .clk        (clk),
    .ctl        (ctl),
    .pixel_x    (in_tdata[7:0]),
    .pixel_y    (in_tdata[15:8]),
    .layer      (in_tuser),
    .win0_rect  (win0_r),
    .win1_rect  (win1_r),
    .win_en     (win_en_r),
    .blend_mode (mode_r),
    .op_r       (op1_r)
  );

  // write enable rides along with the channels
  always_ff @(posedge clk) begin
    if (ctl.ld2) we2_r <= (op1_r != OP_KEEP);
    if (ctl.ld3) we3_r <= we2_r;
  end

  for (genvar c = 0; c < NCHAN; c++) begin : g_chan
    wmpb_mix u_mix (
      .clk   (clk),
      .ctl   (ctl),
      .op    (op1_r),
      .src   (src1_r[c]),
      .dst   (dst1_r[c]),
      .ca    (ca_sat),
      .cb    (cb_sat),
      .ev    (ev_sat),
      .res_r (res[c])
    );
  end

  assign out_tvalid = vld_r[2];
  assign out_tuser  = we3_r;
  assign out_tdata  = {res[2], res[1], res[0]};

  // input stalls only with a full pipeline
  a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (vld_r == 3'b111))
    else $error("input stalled with a bubble in the pipeline");

  // an accepted transfer lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted pixel missing from stage 1");

  // a blocked stage 1 item is not dropped
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && !ctl.ld2) |=> vld_r[0])
    else $error("stage 1 pixel lost during stall");

  // a blocked stage 2 item is not dropped
  a_s2_held: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && !ctl.ld3) |=> (vld_r[1] && $stable(we2_r)))
    else $error("stage 2 pixel lost during stall");

endmodule

>>> rtl/core/wmpb_win.sv
// window stage: picks the window mask and decides the per-pixel operation
// depends on wmpb_pkg
module wmpb_win (
  input  logic                         clk,
  input  wmpb_pkg::pipe_ctl_t          ctl,
  input  logic [7:0]                   pixel_x,
  input  logic [7:0]                   pixel_y,
  input  logic [wmpb_pkg::LAYER_W-1:0] layer,
  input  logic [wmpb_pkg::RECT_W-1:0]  win0_rect,
  input  logic [wmpb_pkg::RECT_W-1:0]  win1_rect,
  input  logic [wmpb_pkg::EN_W-1:0]    win_en,
  input  logic [1:0]                   blend_mode,
  output wmpb_pkg::op_t                op_r
);
  import wmpb_pkg::*;

  logic [MASK_W-1:0] mask;
  logic [7:0]        mask_ext;
  logic              shown;
  logic              fx;
  op_t               op_nxt;

  // window 0 wins over window 1, outside mask otherwise
  always_comb begin
    if (inside_rect(win0_rect, pixel_x, pixel_y)) begin
      mask = win_en[MASK_W-1:0];
    end else if (inside_rect(win1_rect, pixel_x, pixel_y)) begin
      mask = win_en[2*MASK_W-1:MASK_W];
    end else begin
      mask = win_en[3*MASK_W-1:2*MASK_W];
    end
  end

  // layer codes above the object layer are never shown
  assign mask_ext = {2'b00, mask};
  assign shown    = (layer <= LAYER_OBJ) && mask_ext[layer];
  assign fx       = mask[FX_BIT];

  always_comb begin
    if (!shown) begin
      op_nxt = OP_KEEP;
    end else if (!fx) begin
      op_nxt = OP_PASS;
    end else begin
      case (mode_t'(blend_mode))
        MODE_ALPHA:  op_nxt = OP_ALPHA;
        MODE_BRIGHT: op_nxt = OP_BRIGHT;
        MODE_DARK:   op_nxt = OP_DARK;
        default:     op_nxt = OP_PASS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      op_r <= op_nxt;
    end
  end

endmodule

>>> rtl/core/wmpb_mix.sv
// one color channel: product stage then sum, scale and clamp stage
// depends on wmpb_pkg
module wmpb_mix (
  input  logic                        clk,
  input  wmpb_pkg::pipe_ctl_t         ctl,
  input  wmpb_pkg::op_t               op,
  input  logic [wmpb_pkg::CHAN_W-1:0] src,
  input  logic [wmpb_pkg::CHAN_W-1:0] dst,
  input  logic [wmpb_pkg::COEF_W-1:0] ca,
  input  logic [wmpb_pkg::COEF_W-1:0] cb,
  input  logic [wmpb_pkg::COEF_W-1:0] ev,
  output logic [wmpb_pkg::CHAN_W-1:0] res_r
);
  import wmpb_pkg::*;

  op_t               op2_r;
  logic [CHAN_W-1:0] s2_r, d2_r;
  logic [PROD_W-1:0] p0_r, p1_r;
  logic [PROD_W-1:0] p0_nxt, p1_nxt;
  logic [PROD_W:0]   sum;
  logic [CHAN_W:0]   bsum;
  logic [CHAN_W-1:0] res_nxt;

  // stage 2: one product per operand
  always_comb begin
    p0_nxt = '0;
    p1_nxt = '0;
    case (op)
      OP_ALPHA: begin
        p0_nxt = {5'd0, src} * {8'd0, ca};
        p1_nxt = {5'd0, dst} * {8'd0, cb};
      end
      OP_BRIGHT: p0_nxt = {5'd0, 8'hFF - src} * {8'd0, ev};
      OP_DARK:   p0_nxt = {5'd0, src} * {8'd0, 5'd16 - ev};
      default: begin
        p0_nxt = '0;
        p1_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      op2_r <= op;
      s2_r  <= src;
      d2_r  <= dst;
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
    end
  end

  // stage 3: add, divide by sixteen, clamp
  assign sum  = {1'b0, p0_r} + {1'b0, p1_r};
  assign bsum = {1'b0, s2_r} + {1'b0, p0_r[11:4]};

  always_comb begin
    case (op2_r)
      OP_ALPHA:  res_nxt = (|sum[PROD_W:12]) ? 8'hFF : sum[11:4];
      OP_BRIGHT: res_nxt = bsum[CHAN_W] ? 8'hFF : bsum[CHAN_W-1:0];
      OP_DARK:   res_nxt = p0_r[11:4];
      OP_PASS:   res_nxt = s2_r;
      default:   res_nxt = d2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      res_r <= res_nxt;
    end
  end

endmodule
